// ===== design/sar_pkg.sv =====
// sar_pkg: shared field widths, packet class codes and the stage control struct
// for the selective ack receiver
// no dependencies
package sar_pkg;

   localparam int CONN_W     = 6;
   localparam int SEQ_IN_W   = 24;
   localparam int CLASS_W    = 2;
   localparam int MSN_W      = 24;
   localparam int DONE_W     = 8;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 80;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_MIDDLE    = 2'd0,
      CLASS_LAST      = 2'd1,
      CLASS_LAST_CMPL = 2'd2
   } packet_class_type;

   typedef struct packed {
      logic hit;
      logic ahead;
      logic is_last;
      logic completes;
   } sar_ctl_type;

endpackage

// ===== design/sar_rec_mem.sv =====
// sar_rec_mem: per-connection record store, one write and one read port,
// read data registered; depends on nothing
module sar_rec_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 304
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== design/sar_scan.sv =====
// sar_scan: first stage of the record update, finds the run of arrived
// packets after the expected one and the bit an early packet sets; uses sar_pkg
module sar_scan
   import sar_pkg::*;
#(
   parameter int WINDOW_BITS = 128,
   parameter int SEQ_BITS    = 24,
   parameter int CW          = 6
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic [CW-1:0]                conn,
   input  logic [SEQ_BITS-1:0]          seq,
   input  logic [CLASS_W-1:0]           cls,
   input  logic [WINDOW_BITS-1:0]       pb,
   input  logic [WINDOW_BITS-1:0]       lb,
   input  logic [SEQ_BITS-1:0]          exp,
   input  logic [MSN_W-1:0]             msn,
   output logic [CW-1:0]                conn_ff,
   output sar_ctl_type                  ctl_ff,
   output logic [SEQ_BITS-1:0]          seq_ff,
   output logic [WINDOW_BITS-1:0]       pb_ff,
   output logic [WINDOW_BITS-1:0]       lb_ff,
   output logic [SEQ_BITS-1:0]          exp_ff,
   output logic [MSN_W-1:0]             msn_ff,
   output logic [WINDOW_BITS-1:0]       below_ff,
   output logic [$clog2(WINDOW_BITS+1)-1:0] sh_ff,
   output logic [WINDOW_BITS-1:0]       set_mask_ff
);

   localparam int WB = $clog2(WINDOW_BITS);
   localparam int SW = $clog2(WINDOW_BITS + 1);
   localparam logic [WINDOW_BITS-1:0] BIT0 = WINDOW_BITS'(1);

   logic [WINDOW_BITS-1:0] occ;
   logic [WINDOW_BITS-1:0] gap;
   logic [WINDOW_BITS-1:0] first_gap;
   logic [WINDOW_BITS-1:0] below;
   logic [WINDOW_BITS-1:0] set_mask;
   logic [SW-1:0]          sh;
   logic [31:0]            seq32;
   logic [31:0]            exp32;
   logic [31:0]            off32;
   sar_ctl_type            ctl;

   always_comb begin
      // bit 0 is the packet itself, always consumed on a hit
      occ       = pb | lb | BIT0;
      gap       = ~occ;
      below     = ~gap & (gap - BIT0);
      first_gap = gap & (~gap + BIT0);
      sh        = '0;
      for (int i = 0; i < WINDOW_BITS; i++) begin
         if (first_gap[i]) begin
            sh = sh | SW'(i);
         end
      end
      if (gap == '0) begin
         sh = SW'(WINDOW_BITS);
      end

      seq32 = 32'(seq);
      exp32 = 32'(exp);
      off32 = seq32 - exp32;
      if (off32 < 32'(WINDOW_BITS)) begin
         set_mask = BIT0 << off32[WB-1:0];
      end else begin
         set_mask = '0;
      end

      ctl.hit       = (seq == exp);
      ctl.ahead     = (seq32 > exp32);
      ctl.is_last   = (cls != CLASS_MIDDLE);
      // the unused class code counts as last with completion
      ctl.completes = (cls != CLASS_MIDDLE) && (cls != CLASS_LAST);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         conn_ff     <= conn;
         ctl_ff      <= ctl;
         seq_ff      <= seq;
         pb_ff       <= pb;
         lb_ff       <= lb;
         exp_ff      <= exp;
         msn_ff      <= msn;
         below_ff    <= below;
         sh_ff       <= sh;
         set_mask_ff <= set_mask;
      end
   end

endmodule

// ===== design/sar_apply.sv =====
// sar_apply: second stage of the record update, shifts the bitmaps, counts
// finished messages and completions and forms the ack; uses sar_pkg
module sar_apply
   import sar_pkg::*;
#(
   parameter int WINDOW_BITS = 128,
   parameter int SEQ_BITS    = 24
) (
   input  sar_ctl_type                      ctl,
   input  logic [SEQ_BITS-1:0]              seq,
   input  logic [WINDOW_BITS-1:0]           pb,
   input  logic [WINDOW_BITS-1:0]           lb,
   input  logic [SEQ_BITS-1:0]              exp,
   input  logic [MSN_W-1:0]                 msn,
   input  logic [WINDOW_BITS-1:0]           below,
   input  logic [$clog2(WINDOW_BITS+1)-1:0] sh,
   input  logic [WINDOW_BITS-1:0]           set_mask,
   output logic [WINDOW_BITS-1:0]           new_pb,
   output logic [WINDOW_BITS-1:0]           new_lb,
   output logic [SEQ_BITS-1:0]              new_exp,
   output logic [MSN_W-1:0]                 new_msn,
   output logic                             nack,
   output logic [SEQ_IN_W-1:0]              cum_ack,
   output logic [SEQ_IN_W-1:0]              sel_ack,
   output logic [DONE_W-1:0]                done
);

   localparam int SW = $clog2(WINDOW_BITS + 1);
   localparam logic [WINDOW_BITS-1:0] BIT0 = WINDOW_BITS'(1);

   logic [WINDOW_BITS-1:0] run_bits;
   logic [SW-1:0]          last_cnt;
   logic [SW-1:0]          cmpl_cnt;
   logic [SW-1:0]          done_sum;
   logic [31:0]            exp_sum;
   logic [31:0]            done32;
   logic [31:0]            exp32;
   logic [31:0]            seq32;

   always_comb begin
      run_bits = below & ~BIT0;
      last_cnt = SW'($countones(lb & run_bits));
      cmpl_cnt = SW'($countones(pb & lb & run_bits));
      exp_sum  = 32'(exp) + 32'(sh);
      done_sum = '0;
      new_pb   = pb;
      new_lb   = lb;
      new_exp  = exp;
      new_msn  = msn;
      nack     = 1'b0;

      priority if (ctl.hit) begin
         new_pb   = pb >> sh;
         new_lb   = lb >> sh;
         new_exp  = exp_sum[SEQ_BITS-1:0];
         new_msn  = msn + MSN_W'(ctl.is_last) + MSN_W'(last_cnt);
         done_sum = SW'(ctl.completes) + cmpl_cnt;
      end else if (ctl.ahead) begin
         nack = 1'b1;
         if (ctl.is_last) begin
            new_lb = lb | set_mask;
         end
         if (ctl.completes || !ctl.is_last) begin
            new_pb = pb | set_mask;
         end
      end else begin
         nack = 1'b0;
      end

      done32  = 32'(done_sum);
      done    = done32[DONE_W-1:0];
      exp32   = 32'(new_exp);
      cum_ack = exp32[SEQ_IN_W-1:0];
      seq32   = 32'(seq);
      sel_ack = seq32[SEQ_IN_W-1:0];
   end

endmodule

// ===== design/selective_ack_receiver.sv =====
// selective_ack_receiver: top level, record store, issue control, bypass of
// the last written record and the result register
// uses sar_pkg, sar_rec_mem, sar_scan, sar_apply
//
//   channel   dir  contents
//   req_*     in   connection, seq_no (tdata), packet_class (tuser)
//   rsp_*     out  cumulative_ack, message_count, selective_ack,
//                  completions_done (tdata), nack (tuser)
//
// no new item is taken while one waits in the scan stage: the record
// read-modify-write of one item (scan stage then apply stage with write-back)
// must land before the next item scans. an item's result passes the scan stage
// register and the apply stage and is held in the result register that drives rsp.
// after reset a clearing pass over all CONNECTIONS entries zeroes the record
// store, with req_tready low. a result stalled on rsp holds the apply stage;
// one more item is taken and waits in the scan stage.
module selective_ack_receiver
   import sar_pkg::*;
#(
   parameter int WINDOW_BITS = 128,
   parameter int CONNECTIONS = 64,
   parameter int SEQ_BITS    = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [5:0] connection, [29:6] seq_no, [31:30] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] packet_class
   input  logic [CLASS_W-1:0]    req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [23:0] cumulative_ack, [47:24] message_count, [71:48] selective_ack,
   // [79:72] completions_done
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] nack
   output logic [0:0]            rsp_tuser
);

   localparam int CW    = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
   localparam int SW    = $clog2(WINDOW_BITS + 1);
   localparam int REC_W = 2 * WINDOW_BITS + SEQ_BITS + MSN_W;
   localparam int LB_LO = WINDOW_BITS;
   localparam int EX_LO = 2 * WINDOW_BITS;
   localparam int MS_LO = 2 * WINDOW_BITS + SEQ_BITS;
   localparam int NCONN = 1 << CONN_W;

   // connection number folded onto the store depth
   logic [CW-1:0] conn_map [NCONN];

   for (genvar g = 0; g < NCONN; g++) begin : g_conn
      localparam int unsigned CIDX = g % CONNECTIONS;
      assign conn_map[g] = CW'(CIDX);
   end

   logic [CONN_W-1:0]    req_conn;
   logic [SEQ_IN_W-1:0]  req_seq;
   logic [31:0]          req_seq32;
   logic                 accept;

   logic                 clear_ff, clear_in;
   logic [CW-1:0]        clr_idx_ff, clr_idx_in;
   logic                 x1_valid_ff, x1_valid_in;
   logic                 x2_valid_ff, x2_valid_in;
   logic                 x1_adv;
   logic                 x2_adv;
   logic [CW-1:0]        x1_conn_ff;
   logic [SEQ_BITS-1:0]  x1_seq_ff;
   logic [CLASS_W-1:0]   x1_cls_ff;

   logic                 byp_valid_ff, byp_valid_in;
   logic [CW-1:0]        byp_conn_ff;
   logic [REC_W-1:0]     byp_rec_ff;

   logic [REC_W-1:0]     rd_rec;
   logic [REC_W-1:0]     x1_rec;
   logic [REC_W-1:0]     wr_rec;
   logic                 wr_en;
   logic [CW-1:0]        wr_addr;
   logic [REC_W-1:0]     wr_data;

   logic [CW-1:0]            x2_conn;
   sar_ctl_type              x2_ctl;
   logic [SEQ_BITS-1:0]      x2_seq;
   logic [WINDOW_BITS-1:0]   x2_pb;
   logic [WINDOW_BITS-1:0]   x2_lb;
   logic [SEQ_BITS-1:0]      x2_exp;
   logic [MSN_W-1:0]         x2_msn;
   logic [WINDOW_BITS-1:0]   x2_below;
   logic [SW-1:0]            x2_sh;
   logic [WINDOW_BITS-1:0]   x2_set_mask;

   logic [WINDOW_BITS-1:0]   new_pb;
   logic [WINDOW_BITS-1:0]   new_lb;
   logic [SEQ_BITS-1:0]      new_exp;
   logic [MSN_W-1:0]         new_msn;
   logic                     res_nack;
   logic [SEQ_IN_W-1:0]      res_cum;
   logic [SEQ_IN_W-1:0]      res_sel;
   logic [DONE_W-1:0]        res_done;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic                     rsp_nack_ff;

   assign req_conn   = req_tdata[CONN_W-1:0];
   assign req_seq    = req_tdata[CONN_W+SEQ_IN_W-1:CONN_W];
   assign req_seq32  = 32'(req_seq);

   assign req_tready = !clear_ff && !x1_valid_ff;
   assign accept     = req_tvalid && req_tready;
   // the scan stage moves on only once the previous write is in the bypass
   assign x1_adv     = x1_valid_ff && !x2_valid_ff;
   assign x2_adv     = x2_valid_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      clear_in     = clear_ff;
      clr_idx_in   = clr_idx_ff;
      if (clear_ff) begin
         clr_idx_in = clr_idx_ff + CW'(1);
         if (clr_idx_ff == CW'(CONNECTIONS - 1)) begin
            clear_in = 1'b0;
         end
      end

      x1_valid_in  = x1_valid_ff;
      if (accept) begin
         x1_valid_in = 1'b1;
      end else if (x1_adv) begin
         x1_valid_in = 1'b0;
      end

      x2_valid_in  = x2_valid_ff;
      if (x1_adv) begin
         x2_valid_in = 1'b1;
      end else if (x2_adv) begin
         x2_valid_in = 1'b0;
      end

      byp_valid_in = byp_valid_ff || x2_adv;

      rsp_valid_in = rsp_valid_ff;
      if (x2_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_idx_ff   <= '0;
         x1_valid_ff  <= 1'b0;
         x2_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clr_idx_ff   <= clr_idx_in;
         x1_valid_ff  <= x1_valid_in;
         x2_valid_ff  <= x2_valid_in;
         byp_valid_ff <= byp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x1_conn_ff <= conn_map[req_conn];
         x1_seq_ff  <= req_seq32[SEQ_BITS-1:0];
         x1_cls_ff  <= req_tuser;
      end
      if (x2_adv) begin
         byp_conn_ff <= x2_conn;
         byp_rec_ff  <= wr_rec;
         rsp_nack_ff <= res_nack;
         rsp_data_ff <= {res_done, res_sel, new_msn, res_cum};
      end
   end

   assign wr_rec  = {new_msn, new_exp, new_lb, new_pb};
   assign wr_en   = clear_ff || x2_adv;
   assign wr_addr = clear_ff ? clr_idx_ff : x2_conn;
   assign wr_data = clear_ff ? '0 : wr_rec;

   sar_rec_mem #(
      .DEPTH  (CONNECTIONS),
      .ADDR_W (CW),
      .DATA_W (REC_W)
   ) u_mem (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (accept),
      .rd_addr    (conn_map[req_conn]),
      .rd_data_ff (rd_rec)
   );

   // the store read may predate the last write to the same connection
   assign x1_rec = (byp_valid_ff && (byp_conn_ff == x1_conn_ff)) ? byp_rec_ff : rd_rec;

   sar_scan #(
      .WINDOW_BITS (WINDOW_BITS),
      .SEQ_BITS    (SEQ_BITS),
      .CW          (CW)
   ) u_scan (
      .clock       (clock),
      .load        (x1_adv),
      .conn        (x1_conn_ff),
      .seq         (x1_seq_ff),
      .cls         (x1_cls_ff),
      .pb          (x1_rec[WINDOW_BITS-1:0]),
      .lb          (x1_rec[LB_LO+WINDOW_BITS-1:LB_LO]),
      .exp         (x1_rec[EX_LO+SEQ_BITS-1:EX_LO]),
      .msn         (x1_rec[MS_LO+MSN_W-1:MS_LO]),
      .conn_ff     (x2_conn),
      .ctl_ff      (x2_ctl),
      .seq_ff      (x2_seq),
      .pb_ff       (x2_pb),
      .lb_ff       (x2_lb),
      .exp_ff      (x2_exp),
      .msn_ff      (x2_msn),
      .below_ff    (x2_below),
      .sh_ff       (x2_sh),
      .set_mask_ff (x2_set_mask)
   );

   sar_apply #(
      .WINDOW_BITS (WINDOW_BITS),
      .SEQ_BITS    (SEQ_BITS)
   ) u_apply (
      .ctl      (x2_ctl),
      .seq      (x2_seq),
      .pb       (x2_pb),
      .lb       (x2_lb),
      .exp      (x2_exp),
      .msn      (x2_msn),
      .below    (x2_below),
      .sh       (x2_sh),
      .set_mask (x2_set_mask),
      .new_pb   (new_pb),
      .new_lb   (new_lb),
      .new_exp  (new_exp),
      .new_msn  (new_msn),
      .nack     (res_nack),
      .cum_ack  (res_cum),
      .sel_ack  (res_sel),
      .done     (res_done)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_nack_ff;

endmodule
